// ----- sv/yuv_to_rgb565_tiled_texel_top_defines.svh -----
// Assertion macros for the YCbCr to RGB565 tiled texel block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef YUV_TO_RGB565_TILED_TEXEL_TOP_DEFINES_SVH
`define YUV_TO_RGB565_TILED_TEXEL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define YTR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define YTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ytr_pkg.sv -----
// Shared constants for the YCbCr to RGB565 tiled texel block.
// No dependencies; imported by ytr_texel_addr and the top level.
`default_nettype none

package ytr_pkg;

    // Texture geometry (powers of two)
    localparam int unsigned CELL_WIDTH  = 128;
    localparam int unsigned CELL_HEIGHT = 128;
    localparam int unsigned MAX_CELLS   = 16;
    localparam int unsigned CELL_BYTES  = CELL_WIDTH * CELL_HEIGHT * 2;
    localparam int unsigned TILE_BYTES  = 32;

    // Field widths
    localparam int unsigned SAMPLE_W = 8;
    localparam int unsigned CELL_W   = 4;
    localparam int unsigned COORD_W  = 7;
    localparam int unsigned PIXEL_W  = 16;
    localparam int unsigned ADDR_W   = 19;

    // Internal arithmetic widths
    localparam int unsigned ACC_W  = 20;
    localparam int unsigned CHAN_W = ACC_W - 8;
    localparam int unsigned COEF_W = 11;

    // Full-range coefficients (8 fractional bits)
    localparam logic signed [COEF_W-1:0] FULL_R_CR = 11'sd359;
    localparam logic signed [COEF_W-1:0] FULL_G_CB = -11'sd88;
    localparam logic signed [COEF_W-1:0] FULL_G_CR = -11'sd183;
    localparam logic signed [COEF_W-1:0] FULL_B_CB = 11'sd454;

    // Studio-range coefficients (8 fractional bits)
    localparam logic signed [COEF_W-1:0] STUDIO_Y    = 11'sd298;
    localparam logic signed [COEF_W-1:0] STUDIO_R_CR = 11'sd409;
    localparam logic signed [COEF_W-1:0] STUDIO_G_CB = -11'sd100;
    localparam logic signed [COEF_W-1:0] STUDIO_G_CR = -11'sd208;
    localparam logic signed [COEF_W-1:0] STUDIO_B_CB = 11'sd516;

    localparam logic [SAMPLE_W-1:0] CHROMA_OFFSET = 8'd128;
    localparam logic [SAMPLE_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 20'sd128;
    // Turns the floor of a subtracted term into a ceiling
    localparam logic signed [ACC_W-1:0] ROUND_CEIL = 20'sd255;

endpackage

`default_nettype wire

// ----- sv/yuv_to_rgb565_tiled_texel_top.sv -----
// Top level of the YCbCr to RGB565 tiled texel converter.
// Depends on ytr_pkg, ytr_texel_addr and yuv_to_rgb565_tiled_texel_top_defines.svh.
`default_nettype none

// Converts one BT.601 YCbCr pixel per clock, while in_stall is low, to RGB565
// and gives the byte address of its high byte in a texture of 128x128 cells
// tiled as 4x4 texels. The datapath is three register stages: products and
// texel address, then the channel sums with a floor shift by 8, then clamp to
// 0..255 and packing into the output register. A new transaction can enter
// every cycle that in_stall is low. Each stage holds its data only while the
// stage after it is full and held, so in_stall rises only when all three
// stages are occupied and the output transaction is stalled. The range
// register (reset 1) picks full-range JPEG coefficients; 0 picks studio range
// with the luma offset of 16. Write it with cfg_we/cfg_data only while no
// transaction is in flight.
`include "yuv_to_rgb565_tiled_texel_top_defines.svh"

module yuv_to_rgb565_tiled_texel_top
    import ytr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_we,
    input  wire logic                cfg_data,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [SAMPLE_W-1:0] luma,
    input  wire logic [SAMPLE_W-1:0] chroma_blue,
    input  wire logic [SAMPLE_W-1:0] chroma_red,
    input  wire logic [CELL_W-1:0]   cell_number,
    input  wire logic [COORD_W-1:0]  column_in_cell,
    input  wire logic [COORD_W-1:0]  row_in_cell,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [PIXEL_W-1:0]       rgb565,
    output logic [ADDR_W-1:0]        byte_address
);

    // Clamp a signed channel to 0..255
    function automatic logic [SAMPLE_W-1:0] clamp8(input logic signed [CHAN_W-1:0] v);
        logic [SAMPLE_W-1:0] res;
        if (v < 0)
            res = '0;
        else if (v > 12'sd255)
            res = '1;
        else
            res = v[SAMPLE_W-1:0];
        return res;
    endfunction

    // Configuration register
    logic jpeg_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            jpeg_range_reg <= 1'b1;
        else if (cfg_we)
            jpeg_range_reg <= cfg_data;
    end

    // Pipeline control: a stage takes new data when empty or when its
    // successor moves on
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic s1_ready;
    logic s2_ready;
    logic s3_ready;
    logic in_take;

    assign s3_ready = !out_valid_reg || !out_stall;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;
    assign in_take  = in_valid && s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // Stage 1: remove chroma offset, form products and the luma base term.
    // Full range uses 256*Y as base so that Y + floor(p/256) = floor((256Y+p)/256);
    // green subtracts, so its base gets +255 to turn the floor into a ceiling.
    logic signed [SAMPLE_W:0]   cb_off;
    logic signed [SAMPLE_W:0]   cr_off;
    logic signed [SAMPLE_W:0]   luma_off;
    logic signed [COEF_W-1:0]   coef_r_cr;
    logic signed [COEF_W-1:0]   coef_g_cb;
    logic signed [COEF_W-1:0]   coef_g_cr;
    logic signed [COEF_W-1:0]   coef_b_cb;
    logic signed [ACC_W-1:0]    luma_scaled;
    logic signed [ACC_W-1:0]    studio_base;
    logic signed [ACC_W-1:0]    base_rb_next;
    logic signed [ACC_W-1:0]    base_g_next;
    logic signed [ACC_W-1:0]    prod_r_next;
    logic signed [ACC_W-1:0]    prod_gb_next;
    logic signed [ACC_W-1:0]    prod_gr_next;
    logic signed [ACC_W-1:0]    prod_b_next;
    logic        [ADDR_W-1:0]   addr_next;

    logic signed [ACC_W-1:0]    base_rb_reg;
    logic signed [ACC_W-1:0]    base_g_reg;
    logic signed [ACC_W-1:0]    prod_r_reg;
    logic signed [ACC_W-1:0]    prod_gb_reg;
    logic signed [ACC_W-1:0]    prod_gr_reg;
    logic signed [ACC_W-1:0]    prod_b_reg;
    logic        [ADDR_W-1:0]   s1_addr_reg;

    always_comb
    begin
        cb_off   = signed'({1'b0, chroma_blue}) - signed'({1'b0, CHROMA_OFFSET});
        cr_off   = signed'({1'b0, chroma_red}) - signed'({1'b0, CHROMA_OFFSET});
        luma_off = signed'({1'b0, luma}) - signed'({1'b0, LUMA_OFFSET});

        coef_r_cr = jpeg_range_reg ? FULL_R_CR : STUDIO_R_CR;
        coef_g_cb = jpeg_range_reg ? FULL_G_CB : STUDIO_G_CB;
        coef_g_cr = jpeg_range_reg ? FULL_G_CR : STUDIO_G_CR;
        coef_b_cb = jpeg_range_reg ? FULL_B_CB : STUDIO_B_CB;

        luma_scaled = signed'(ACC_W'({luma, 8'd0}));
        studio_base = STUDIO_Y * luma_off + ROUND_HALF;

        base_rb_next = jpeg_range_reg ? luma_scaled : studio_base;
        base_g_next  = jpeg_range_reg ? luma_scaled + ROUND_CEIL : studio_base;

        prod_r_next  = coef_r_cr * cr_off;
        prod_gb_next = coef_g_cb * cb_off;
        prod_gr_next = coef_g_cr * cr_off;
        prod_b_next  = coef_b_cb * cb_off;
    end

    ytr_texel_addr u_texel_addr (
        .cell_number    (cell_number),
        .column_in_cell (column_in_cell),
        .row_in_cell    (row_in_cell),
        .byte_address   (addr_next)
    );

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            base_rb_reg <= base_rb_next;
            base_g_reg  <= base_g_next;
            prod_r_reg  <= prod_r_next;
            prod_gb_reg <= prod_gb_next;
            prod_gr_reg <= prod_gr_next;
            prod_b_reg  <= prod_b_next;
            s1_addr_reg <= addr_next;
        end
    end

    // Stage 2: sum and floor-shift by 8 (arithmetic shift = drop low bits)
    logic signed [ACC_W-1:0]  sum_r;
    logic signed [ACC_W-1:0]  sum_g;
    logic signed [ACC_W-1:0]  sum_b;
    logic signed [CHAN_W-1:0] chan_r_reg;
    logic signed [CHAN_W-1:0] chan_g_reg;
    logic signed [CHAN_W-1:0] chan_b_reg;
    logic        [ADDR_W-1:0] s2_addr_reg;

    always_comb
    begin
        sum_r = base_rb_reg + prod_r_reg;
        sum_g = base_g_reg + prod_gb_reg + prod_gr_reg;
        sum_b = base_rb_reg + prod_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_ready)
        begin
            chan_r_reg  <= signed'(sum_r[ACC_W-1:8]);
            chan_g_reg  <= signed'(sum_g[ACC_W-1:8]);
            chan_b_reg  <= signed'(sum_b[ACC_W-1:8]);
            s2_addr_reg <= s1_addr_reg;
        end
    end

    // Stage 3: clamp and pack into the output register
    logic [SAMPLE_W-1:0] red8;
    logic [SAMPLE_W-1:0] green8;
    logic [SAMPLE_W-1:0] blue8;
    logic [PIXEL_W-1:0]  rgb565_next;
    logic [PIXEL_W-1:0]  rgb565_reg;
    logic [ADDR_W-1:0]   out_addr_reg;

    always_comb
    begin
        red8        = clamp8(chan_r_reg);
        green8      = clamp8(chan_g_reg);
        blue8       = clamp8(chan_b_reg);
        rgb565_next = {red8[7:3], green8[7:2], blue8[7:3]};
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            rgb565_reg   <= rgb565_next;
            out_addr_reg <= s2_addr_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rgb565       = rgb565_reg;
    assign byte_address = out_addr_reg;

    // Checks on the pipeline control
    `YTR_ASSERT_NOW(a_stall_only_when_full, in_stall,
        s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall,
        "input stalled while the pipeline has room")
    `YTR_ASSERT_NEXT(a_accept_fills_s1, in_valid && !in_stall, s1_valid_reg,
        "accepted transaction did not reach stage 1")
    `YTR_ASSERT_NEXT(a_s2_reaches_out, s2_valid_reg && s3_ready, out_valid_reg,
        "stage 2 transaction lost on its way to the output")

endmodule

`default_nettype wire

// ----- sv/ytr_texel_addr.sv -----
// Byte address of a texel in a texture of cells tiled as 4x4 texels.
// Depends on ytr_pkg for the geometry constants.
`default_nettype none

module ytr_texel_addr
    import ytr_pkg::*;
(
    input  wire logic [CELL_W-1:0]  cell_number,
    input  wire logic [COORD_W-1:0] column_in_cell,
    input  wire logic [COORD_W-1:0] row_in_cell,
    output logic      [ADDR_W-1:0]  byte_address
);

    logic [31:0] cell_idx;
    logic [31:0] col_idx;
    logic [31:0] row_idx;
    logic [31:0] tile_offset;
    logic [31:0] texel_offset;
    logic [31:0] addr_sum;

    always_comb
    begin
        // Wrap out-of-range values; all sizes are powers of two, so these are masks
        cell_idx = 32'(cell_number) % MAX_CELLS;
        col_idx  = 32'(column_in_cell) % CELL_WIDTH;
        row_idx  = 32'(row_in_cell) % CELL_HEIGHT;

        tile_offset  = ((row_idx >> 2) * (CELL_WIDTH / 4) + (col_idx >> 2)) * TILE_BYTES;
        texel_offset = ((row_idx & 32'd3) * 32'd4 + (col_idx & 32'd3)) * 32'd2;
        addr_sum     = cell_idx * CELL_BYTES + tile_offset + texel_offset;
    end

    assign byte_address = addr_sum[ADDR_W-1:0];

endmodule

`default_nettype wire
